FILE: hdl/length_prefixed_frame_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame deframer
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer package
// Types, codes and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam int LPFD_BUFFER_BYTES = 256;
    // Positions are eight bits wide, so a frame total must stay below this.
    localparam int LPFD_POS_LIMIT    = 256;

    localparam logic [7:0] LPFD_TYPE_A     = 8'h01;
    localparam logic [7:0] LPFD_TYPE_B     = 8'h02;
    localparam logic [7:0] LPFD_LEN_ESCAPE = 8'd255;

    // Byte counts (position plus one) of the header bytes.
    localparam logic [8:0] LPFD_CNT_TYPE    = 9'd1;
    localparam logic [8:0] LPFD_CNT_LEN     = 9'd2;
    localparam logic [8:0] LPFD_CNT_EXT_LOW = 9'd3;
    localparam logic [8:0] LPFD_CNT_FIX     = 9'd4;

    localparam int LPFD_TDATA_W = 32;

    typedef enum logic [1:0] {
        TMO_NONE  = 2'd0,
        TMO_ARM   = 2'd1,
        TMO_CLEAR = 2'd2
    } lpfd_tmo_t;

    typedef struct packed {
        logic       write_buffer;
        logic [7:0] write_index;
        logic [7:0] write_data;
        logic       frame_done;
        logic       ready_slot;
        logic [7:0] payload_len;
        logic       extended_len;
        lpfd_tmo_t  timeout_action;
        logic       stop_receiver;
    } lpfd_result_t;

endpackage

FILE: hdl/lpfd_in_stage.sv
// ----------------------------------------------------------------------------
// Deframer input stage
// Registers one received word and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module lpfd_in_stage
    import lpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       hold_valid,
    input  logic       hold_ready,
    output logic [7:0] hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The register refills in the same cycle that the parser drains it.
    assign in_ready   = !valid_reg || hold_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

FILE: hdl/lpfd_frame_parser.sv
// ----------------------------------------------------------------------------
// Deframer frame parser
// Tracks the frame header and position, and registers one result per word.
// ----------------------------------------------------------------------------
module lpfd_frame_parser
    import lpfd_pkg::*;
#(
    parameter int BUFFER_BYTES = LPFD_BUFFER_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         uart_mode,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   in_byte,
    output logic         res_valid,
    input  logic         res_ready,
    output lpfd_result_t res
);

    localparam int TOTAL_LIMIT = (BUFFER_BYTES < LPFD_POS_LIMIT) ? BUFFER_BYTES
                                                                  : LPFD_POS_LIMIT;

    logic         active_buffer_reg;
    logic         active_buffer_next;
    logic [7:0]   byte_position_reg;
    logic [7:0]   byte_position_next;
    logic [8:0]   frame_total_reg;
    logic [8:0]   frame_total_next;
    logic [7:0]   length_byte_reg;
    logic [7:0]   length_byte_next;
    logic [7:0]   ext_length_low_reg;
    logic [7:0]   ext_length_low_next;
    logic         out_valid_reg;
    lpfd_result_t out_reg;
    lpfd_result_t out_next;

    logic         take;
    logic [8:0]   count;
    logic [16:0]  total;
    logic         total_ok;
    logic         is_ext;

    assign in_ready = !out_valid_reg || res_ready;
    assign take     = in_ready && in_valid;
    assign count    = {1'b0, byte_position_reg} + 9'd1;
    assign is_ext   = (length_byte_reg == LPFD_LEN_ESCAPE);
    // Extended length is little-endian: low byte came in at count three.
    assign total    = is_ext ? ({1'b0, in_byte, ext_length_low_reg} + 17'd4)
                             : ({9'd0, length_byte_reg} + 17'd2);
    assign total_ok = (total > 17'd4) && (total < 17'(TOTAL_LIMIT));

    always_comb
    begin
        active_buffer_next  = active_buffer_reg;
        byte_position_next  = count[7:0];
        frame_total_next    = frame_total_reg;
        length_byte_next    = length_byte_reg;
        ext_length_low_next = ext_length_low_reg;

        out_next                = '0;
        out_next.write_buffer   = active_buffer_reg;
        out_next.write_index    = byte_position_reg;
        out_next.write_data     = in_byte;
        out_next.timeout_action = TMO_NONE;

        if (count == LPFD_CNT_TYPE)
        begin
            if (in_byte != LPFD_TYPE_A && in_byte != LPFD_TYPE_B)
            begin
                byte_position_next = '0;
            end
            else
            begin
                out_next.timeout_action = TMO_ARM;
            end
        end
        else if (count == LPFD_CNT_LEN)
        begin
            length_byte_next = in_byte;
        end
        else if (count == LPFD_CNT_EXT_LOW)
        begin
            ext_length_low_next = in_byte;
        end
        else if (count == LPFD_CNT_FIX)
        begin
            if (total_ok)
            begin
                frame_total_next = total[8:0];
            end
            else
            begin
                byte_position_next = '0;
            end
        end
        else if (count == frame_total_reg)
        begin
            out_next.frame_done     = 1'b1;
            out_next.ready_slot     = active_buffer_reg;
            out_next.extended_len   = is_ext;
            out_next.payload_len    = is_ext ? 8'(frame_total_reg - 9'd4)
                                             : 8'(frame_total_reg - 9'd2);
            out_next.timeout_action = TMO_CLEAR;
            out_next.stop_receiver  = uart_mode;
            byte_position_next      = '0;
            active_buffer_next      = !active_buffer_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_buffer_reg  <= 1'b0;
            byte_position_reg  <= '0;
            frame_total_reg    <= '0;
            length_byte_reg    <= '0;
            ext_length_low_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                active_buffer_reg  <= active_buffer_next;
                byte_position_reg  <= byte_position_next;
                frame_total_reg    <= frame_total_next;
                length_byte_reg    <= length_byte_next;
                ext_length_low_reg <= ext_length_low_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

FILE: hdl/length_prefixed_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer core
// Places received words into two ping-pong frame buffers and reports
// frame completion, payload length and receive timeout actions.
//
// Channel  Dir  Payload
// s_axis   in   tdata[7:0] rx_byte
// m_axis   out  tdata write_index..stop_receiver, tuser write_buffer,
//               tlast frame_done
// cfg      in   cfg_wdata uart_mode
//
// One word in and one result out per clock while m_axis accepts results; the result
// reaches m_axis through two register stages (input, result) after input acceptance.
// The header parse and position counter settle within the parser stage, which sets the rate.
// Reset clears the position, buffer select and header bytes; uart_mode resets to 1.
// A stall on m_axis holds the result; one more word waits in the input register.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_core
    import lpfd_pkg::*;
#(
    parameter int BUFFER_BYTES = LPFD_BUFFER_BYTES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] rx_byte
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [7:0] write_index, [15:8] write_data, [16] ready_slot, [24:17] payload_len,
    // [25] extended_len, [27:26] timeout_action, [28] stop_receiver, rest zero
    output logic [LPFD_TDATA_W-1:0] m_tdata,
    output logic                    m_tuser,   // [0] write_buffer
    output logic                    m_tlast,   // frame_done
    input  logic                    cfg_we,
    input  logic                    cfg_wdata  // [0] uart_mode
);

    logic         uart_mode_reg;
    logic         hold_valid;
    logic         hold_ready;
    logic [7:0]   hold_byte;
    lpfd_result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uart_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            uart_mode_reg <= cfg_wdata;
        end
    end

    lpfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .hold_valid (hold_valid),
        .hold_ready (hold_ready),
        .hold_byte  (hold_byte)
    );

    lpfd_frame_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .uart_mode (uart_mode_reg),
        .in_valid  (hold_valid),
        .in_ready  (hold_ready),
        .in_byte   (hold_byte),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {3'd0, res.stop_receiver, res.timeout_action, res.extended_len,
                      res.payload_len, res.ready_slot, res.write_data, res.write_index};
    assign m_tuser = res.write_buffer;
    assign m_tlast = res.frame_done;

endmodule

FILE: hdl/lpfd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the top-level ports for result consistency and output stability.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_core_defines.svh"

module lpfd_checker
    import lpfd_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [LPFD_TDATA_W-1:0] m_tdata,
    input logic                    m_tuser,
    input logic                    m_tlast
);

    `LPFD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result word changed")

    // A completed frame always clears the timeout and names the buffer it was written to.
    `LPFD_ASSERT_NOW(a_done_fields, clk, rst_n, m_tvalid && m_tlast, m_tdata[27:26] == TMO_CLEAR && m_tdata[16] == m_tuser, "frame done word has wrong slot or timeout action")

    `LPFD_ASSERT_NOW(a_idle_fields, clk, rst_n, m_tvalid && !m_tlast, m_tdata[25:16] == 10'd0 && !m_tdata[28] && m_tdata[27:26] != TMO_CLEAR, "completion fields set on a word that ends no frame")

    // Arming happens only on the type byte at the start of a buffer.
    `LPFD_ASSERT_NOW(a_arm_at_start, clk, rst_n, m_tvalid && m_tdata[27:26] == TMO_ARM, m_tdata[7:0] == 8'd0 && (m_tdata[15:8] == LPFD_TYPE_A || m_tdata[15:8] == LPFD_TYPE_B), "timeout armed away from a frame start")

endmodule

bind length_prefixed_frame_deframer_core lpfd_checker u_lpfd_checker (.*);
